### rtl/fan_curve_thermal_controller_assert.svh
// assertion macros shared by the fan curve controller rtl
// depends on nothing; included by the top-level module, which checks its own logic
`ifndef FAN_CURVE_THERMAL_CONTROLLER_ASSERT_SVH
`define FAN_CURVE_THERMAL_CONTROLLER_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked outside reset
`define FCT_ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("fct assertion failed");

// next-cycle implication, checked outside reset
`define FCT_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("fct assertion failed");

`else

`define FCT_ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs)
`define FCT_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)

`endif

`endif

### rtl/fct_pkg.sv
// types, constants and curve table for the fan curve controller
// no dependencies; used by fct_divider and fan_curve_thermal_controller
`default_nettype none

package fct_pkg;

	// curve size
	localparam int NUM_POINTS_DEF = 7;
	localparam int TABLE_IDX_W    = 4;

	// datapath widths
	localparam int BYTE_W     = 8;
	localparam int RPM_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int DIVIDEND_W = 17;
	localparam int DIVISOR_W  = 9;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

	// reset values
	localparam logic [7:0]  TEMP_LOW_RST   = 8'd55;
	localparam logic [7:0]  TEMP_HIGH_RST  = 8'd110;
	localparam logic [7:0]  FLOOR_RST      = 8'd22;
	localparam logic [7:0]  CEILING_RST    = 8'd50;
	localparam logic [7:0]  BOOST_RST      = 8'd35;
	localparam logic [7:0]  HELD_TEMP_RST  = 8'd55;
	localparam logic [7:0]  LAST_LIMIT_RST = 8'd22;
	localparam logic [15:0] HELD_RPM_RST   = 16'd2200;

	// mode codes
	localparam logic [7:0] MODE_QUIET = 8'd255;
	localparam logic [7:0] MODE_PERF  = 8'd0;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP_VALID_LOW  = 3'd0,
		REG_TEMP_VALID_HIGH = 3'd1,
		REG_SPEED_FLOOR     = 3'd2,
		REG_SPEED_CEILING   = 3'd3,
		REG_BOOST_THRESHOLD = 3'd4
	} cfg_reg_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_MULT,
		ST_DSTART,
		ST_DIVIDE,
		ST_FINISH
	} fct_state_t;

	// divider status towards the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// curve point temperatures, points past the seventh are zero
	function automatic logic [7:0] curve_temp(input logic [TABLE_IDX_W-1:0] idx);
		logic [7:0] t;
		case (idx)
			4'd0:    t = 8'd70;
			4'd1:    t = 8'd78;
			4'd2:    t = 8'd84;
			4'd3:    t = 8'd88;
			4'd4:    t = 8'd90;
			4'd5:    t = 8'd95;
			4'd6:    t = 8'd100;
			default: t = 8'd0;
		endcase
		return t;
	endfunction

	// curve point speeds, points past the seventh are zero
	function automatic logic [7:0] curve_speed(input logic [TABLE_IDX_W-1:0] idx);
		logic [7:0] s;
		case (idx)
			4'd0:    s = 8'd22;
			4'd1:    s = 8'd24;
			4'd2:    s = 8'd26;
			4'd3:    s = 8'd28;
			4'd4:    s = 8'd30;
			4'd5:    s = 8'd35;
			4'd6:    s = 8'd49;
			default: s = 8'd0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

### rtl/fct_divider.sv
// restoring divider, one quotient bit per cycle
// depends on fct_pkg for widths and the status struct
`default_nettype none

module fct_divider (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [fct_pkg::DIVIDEND_W-1:0]   dividend,
	input  wire logic [fct_pkg::DIVISOR_W-1:0]    divisor,
	output logic      [fct_pkg::DIVIDEND_W-1:0]   quotient,
	output fct_pkg::div_stat_t                    stat
);

	localparam int NW = fct_pkg::DIVIDEND_W;
	localparam int DW = fct_pkg::DIVISOR_W;
	localparam int CW = fct_pkg::DIV_CNT_W;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] num_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dsr_q;
	logic [DW:0]   rem_sh;
	logic          ge;
	logic [DW:0]   rem_sub;

	// trial subtract of the shifted partial remainder
	always_comb begin
		rem_sh  = {rem_q, num_q[NW-1]};
		ge      = rem_sh >= {1'b0, dsr_q};
		rem_sub = rem_sh - {1'b0, dsr_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: quotient bits shift in behind the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], ge};
			rem_q <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
		end
	end

	assign quotient  = num_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

### rtl/fan_curve_thermal_controller.sv
// fan curve controller top level: sequencer, curve search, clamp and mode logic
// depends on fct_pkg, fct_divider and fan_curve_thermal_controller_assert.svh
//
// channel  direction  handshake            payload
// in       sink       in_valid/in_ready    temperatures and tach bytes
// out      source     out_valid/out_ready  mode, limit, held temps, fan rpm
// cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a request steps through search, multiply, divider start, divide and finish; the search
// compares k curve points (1 to NUM_POINTS) and the bit-serial divider takes most of the
// time; a zero-width segment skips the divider
// in_ready is high only while the sequencer is idle; the result register may still
// hold the previous response, and the last step waits for it to drain
// reset restores the configuration and held state at once; cfg_ready is always high
`default_nettype none

module fan_curve_thermal_controller #(
	parameter int NUM_POINTS = fct_pkg::NUM_POINTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input requests
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  cpu_temp_raw,
	input  wire logic [7:0]  gpu_temp_raw,
	input  wire logic [7:0]  cpu_tach_high,
	input  wire logic [7:0]  cpu_tach_low,
	input  wire logic [7:0]  gpu_tach_high,
	input  wire logic [7:0]  gpu_tach_low,
	// results
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             mode_write_valid,
	output logic [7:0]       mode_value,
	output logic             limit_write_valid,
	output logic [7:0]       limit_value,
	output logic [7:0]       cpu_temp_held,
	output logic [7:0]       gpu_temp_held,
	output logic [15:0]      cpu_fan_rpm,
	output logic [15:0]      gpu_fan_rpm,
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	`include "fan_curve_thermal_controller_assert.svh"

	localparam int IW = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
	localparam int TW = fct_pkg::TABLE_IDX_W;
	localparam int NW = fct_pkg::DIVIDEND_W;
	localparam int DW = fct_pkg::DIVISOR_W;
	localparam int LW = NW + 2;

	fct_pkg::fct_state_t state_q, state_d;

	// configuration
	logic [7:0] temp_low_q, temp_high_q, floor_q, ceiling_q, boost_q;

	// held state
	logic [7:0]  held_cpu_temp_q, held_gpu_temp_q;
	logic [15:0] held_cpu_rpm_q, held_gpu_rpm_q;
	logic [7:0]  last_limit_q, last_mode_q;

	// working registers
	logic [7:0]          hot_q;
	logic [IW-1:0]       idx_q;
	logic [IW-1:0]       seg_q;
	logic [7:0]          y1_q;
	logic signed [17:0]  prod_q;
	logic signed [8:0]   den_q;
	logic                neg_q;
	logic                zero_q;

	// result register
	logic        out_valid_q;
	logic        mode_wr_q, limit_wr_q;
	logic [7:0]  mode_val_q, limit_val_q, cpu_held_out_q, gpu_held_out_q;
	logic [15:0] cpu_rpm_out_q, gpu_rpm_out_q;

	// divider interface
	logic                div_start;
	logic [NW-1:0]       div_dividend;
	logic [DW-1:0]       div_divisor;
	logic [NW-1:0]       div_quot;
	fct_pkg::div_stat_t  div_stat;

	// combinational helpers
	logic        in_acc;
	logic        cpu_ok, gpu_ok;
	logic [7:0]  cpu_new, gpu_new;
	logic [7:0]  pt_temp;
	logic        pt_hotter, pt_last;
	logic [IW-1:0] seg_found;
	logic [IW-1:0] seg_nx;
	logic [7:0]  x1, x2, y1, y2;
	logic signed [8:0] dy, dt, den;
	logic        prod_neg, den_neg;
	logic [17:0] prod_abs;
	logic [8:0]  den_abs;
	logic [NW-1:0]     q_eff;
	logic signed [LW-1:0] lim_raw;
	logic [7:0]  lim_clamped;
	logic        lim_changed;
	logic [7:0]  mode_want;
	logic        mode_changed;
	logic        out_free;
	logic        finish_go;

	assign in_ready  = (state_q == fct_pkg::ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	// temperature window check, new or held reading per sensor
	always_comb begin
		cpu_ok  = (cpu_temp_raw >= temp_low_q) && (cpu_temp_raw <= temp_high_q);
		gpu_ok  = (gpu_temp_raw >= temp_low_q) && (gpu_temp_raw <= temp_high_q);
		cpu_new = cpu_ok ? cpu_temp_raw : held_cpu_temp_q;
		gpu_new = gpu_ok ? gpu_temp_raw : held_gpu_temp_q;
	end

	// curve search, one point per cycle
	always_comb begin
		pt_temp   = fct_pkg::curve_temp(TW'(idx_q));
		pt_hotter = pt_temp > hot_q;
		pt_last   = idx_q == IW'(NUM_POINTS - 1);
		if (pt_hotter) begin
			seg_found = (idx_q == '0) ? '0 : idx_q - 1'b1;
		end else begin
			seg_found = IW'(NUM_POINTS - 2);
		end
	end

	// segment end points and the product term
	always_comb begin
		seg_nx = seg_q + 1'b1;
		x1 = fct_pkg::curve_temp(TW'(seg_q));
		x2 = fct_pkg::curve_temp(TW'(seg_nx));
		y1 = fct_pkg::curve_speed(TW'(seg_q));
		y2 = fct_pkg::curve_speed(TW'(seg_nx));
		dy  = $signed({1'b0, y2}) - $signed({1'b0, y1});
		dt  = $signed({1'b0, hot_q}) - $signed({1'b0, x1});
		den = $signed({1'b0, x2}) - $signed({1'b0, x1});
	end

	// rounding division operands: (2|num| + |den|) / (2|den|)
	always_comb begin
		prod_neg     = prod_q[17];
		den_neg      = den_q[8];
		prod_abs     = prod_neg ? 18'(-prod_q) : 18'(prod_q);
		den_abs      = den_neg ? 9'(-den_q) : 9'(den_q);
		div_dividend = {prod_abs[15:0], 1'b0} + NW'(den_abs);
		div_divisor  = {den_abs[7:0], 1'b0};
		div_start    = (state_q == fct_pkg::ST_DSTART) && (den_q != '0);
	end

	// interpolated value, clamp and mode decision
	always_comb begin
		q_eff = zero_q ? '0 : div_quot;
		if (neg_q) begin
			lim_raw = $signed(LW'(y1_q)) - $signed(LW'(q_eff));
		end else begin
			lim_raw = $signed(LW'(y1_q)) + $signed(LW'(q_eff));
		end
		if (lim_raw < $signed(LW'(floor_q))) begin
			lim_clamped = floor_q;
		end else if (lim_raw > $signed(LW'(ceiling_q))) begin
			lim_clamped = ceiling_q;
		end else begin
			lim_clamped = lim_raw[7:0];
		end
		lim_changed  = lim_clamped != last_limit_q;
		mode_want    = (lim_clamped <= boost_q) ? fct_pkg::MODE_QUIET : fct_pkg::MODE_PERF;
		mode_changed = lim_changed && (mode_want != last_mode_q);
	end

	// next state
	always_comb begin
		state_d   = state_q;
		finish_go = 1'b0;
		unique case (state_q)
			fct_pkg::ST_IDLE: begin
				if (in_acc) state_d = fct_pkg::ST_SEARCH;
			end
			fct_pkg::ST_SEARCH: begin
				if (pt_hotter || pt_last) state_d = fct_pkg::ST_MULT;
			end
			fct_pkg::ST_MULT: begin
				state_d = fct_pkg::ST_DSTART;
			end
			fct_pkg::ST_DSTART: begin
				state_d = (den_q == '0) ? fct_pkg::ST_FINISH : fct_pkg::ST_DIVIDE;
			end
			fct_pkg::ST_DIVIDE: begin
				if (div_stat.done) state_d = fct_pkg::ST_FINISH;
			end
			fct_pkg::ST_FINISH: begin
				if (out_free) begin
					finish_go = 1'b1;
					state_d   = fct_pkg::ST_IDLE;
				end
			end
			default: state_d = fct_pkg::ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fct_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_low_q  <= fct_pkg::TEMP_LOW_RST;
			temp_high_q <= fct_pkg::TEMP_HIGH_RST;
			floor_q     <= fct_pkg::FLOOR_RST;
			ceiling_q   <= fct_pkg::CEILING_RST;
			boost_q     <= fct_pkg::BOOST_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fct_pkg::REG_TEMP_VALID_LOW:  temp_low_q  <= cfg_data;
				fct_pkg::REG_TEMP_VALID_HIGH: temp_high_q <= cfg_data;
				fct_pkg::REG_SPEED_FLOOR:     floor_q     <= cfg_data;
				fct_pkg::REG_SPEED_CEILING:   ceiling_q   <= cfg_data;
				fct_pkg::REG_BOOST_THRESHOLD: boost_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// held readings, limit and mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cpu_temp_q <= fct_pkg::HELD_TEMP_RST;
			held_gpu_temp_q <= fct_pkg::HELD_TEMP_RST;
			held_cpu_rpm_q  <= fct_pkg::HELD_RPM_RST;
			held_gpu_rpm_q  <= fct_pkg::HELD_RPM_RST;
			last_limit_q    <= fct_pkg::LAST_LIMIT_RST;
			last_mode_q     <= fct_pkg::MODE_QUIET;
		end else begin
			if (in_acc) begin
				held_cpu_temp_q <= cpu_new;
				held_gpu_temp_q <= gpu_new;
				if (cpu_tach_high != '0 && cpu_tach_low != '0) begin
					held_cpu_rpm_q <= {cpu_tach_high, 8'd0} - {8'd0, cpu_tach_high}
						+ {8'd0, cpu_tach_low};
				end
				if (gpu_tach_high != '0 && gpu_tach_low != '0) begin
					held_gpu_rpm_q <= {gpu_tach_high, 8'd0} - {8'd0, gpu_tach_high}
						+ {8'd0, gpu_tach_low};
				end
			end
			if (finish_go) begin
				last_limit_q <= lim_clamped;
				if (mode_changed) last_mode_q <= mode_want;
			end
		end
	end

	// working datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			hot_q <= (cpu_new > gpu_new) ? cpu_new : gpu_new;
			idx_q <= '0;
		end
		if (state_q == fct_pkg::ST_SEARCH) begin
			idx_q <= idx_q + 1'b1;
			seg_q <= seg_found;
		end
		if (state_q == fct_pkg::ST_MULT) begin
			prod_q <= dy * dt;
			den_q  <= den;
			y1_q   <= y1;
		end
		if (state_q == fct_pkg::ST_DSTART) begin
			neg_q  <= prod_neg ^ den_neg;
			zero_q <= den_q == '0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_go) begin
			mode_wr_q      <= mode_changed;
			mode_val_q     <= mode_changed ? mode_want : last_mode_q;
			limit_wr_q     <= lim_changed;
			limit_val_q    <= lim_clamped;
			cpu_held_out_q <= held_cpu_temp_q;
			gpu_held_out_q <= held_gpu_temp_q;
			cpu_rpm_out_q  <= held_cpu_rpm_q;
			gpu_rpm_out_q  <= held_gpu_rpm_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign mode_write_valid  = mode_wr_q;
	assign mode_value        = mode_val_q;
	assign limit_write_valid = limit_wr_q;
	assign limit_value       = limit_val_q;
	assign cpu_temp_held     = cpu_held_out_q;
	assign gpu_temp_held     = gpu_held_out_q;
	assign cpu_fan_rpm       = cpu_rpm_out_q;
	assign gpu_fan_rpm       = gpu_rpm_out_q;

	// divider
	fct_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quot),
		.stat     (div_stat)
	);

	// checks
	`FCT_ASSERT_IMPLIES(a_done_in_divide, clk, arst_n, div_stat.done,
		state_q == fct_pkg::ST_DIVIDE)
	`FCT_ASSERT_IMPLIES(a_idle_div_quiet, clk, arst_n, in_ready, !div_stat.busy)
	`FCT_ASSERT_IMPLIES(a_mode_with_limit, clk, arst_n, out_valid_q && mode_wr_q,
		limit_wr_q)
	`FCT_ASSERT_IMPLIES(a_limit_in_clamp, clk, arst_n,
		out_valid_q && (floor_q <= ceiling_q),
		(limit_val_q >= floor_q) && (limit_val_q <= ceiling_q))
	`FCT_ASSERT_NEXT(a_start_busy, clk, arst_n, div_start, div_stat.busy)

endmodule

`default_nettype wire

### bench/testbench.sv
// self-checking testbench for fan_curve_thermal_controller: random and directed sensor readings
// depends on fct_pkg and the controller rtl; the expected responses come from an in-bench model
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// index with no register behind it, writes there change nothing
	localparam logic [2:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [7:0] cpu_temp;
		logic [7:0] gpu_temp;
		logic [7:0] cpu_hi;
		logic [7:0] cpu_lo;
		logic [7:0] gpu_hi;
		logic [7:0] gpu_lo;
	} sensor_reading_t;

	typedef struct packed {
		logic        mode_wr;
		logic [7:0]  mode;
		logic        limit_wr;
		logic [7:0]  limit;
		logic [7:0]  cpu_temp;
		logic [7:0]  gpu_temp;
		logic [15:0] cpu_rpm;
		logic [15:0] gpu_rpm;
	} fan_response_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  cpu_temp_raw = '0;
	logic [7:0]  gpu_temp_raw = '0;
	logic [7:0]  cpu_tach_high = '0;
	logic [7:0]  cpu_tach_low = '0;
	logic [7:0]  gpu_tach_high = '0;
	logic [7:0]  gpu_tach_low = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        mode_write_valid;
	logic [7:0]  mode_value;
	logic        limit_write_valid;
	logic [7:0]  limit_value;
	logic [7:0]  cpu_temp_held;
	logic [7:0]  gpu_temp_held;
	logic [15:0] cpu_fan_rpm;
	logic [15:0] gpu_fan_rpm;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	fan_curve_thermal_controller i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.cpu_temp_raw      (cpu_temp_raw),
		.gpu_temp_raw      (gpu_temp_raw),
		.cpu_tach_high     (cpu_tach_high),
		.cpu_tach_low      (cpu_tach_low),
		.gpu_tach_high     (gpu_tach_high),
		.gpu_tach_low      (gpu_tach_low),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.mode_write_valid  (mode_write_valid),
		.mode_value        (mode_value),
		.limit_write_valid (limit_write_valid),
		.limit_value       (limit_value),
		.cpu_temp_held     (cpu_temp_held),
		.gpu_temp_held     (gpu_temp_held),
		.cpu_fan_rpm       (cpu_fan_rpm),
		.gpu_fan_rpm       (gpu_fan_rpm),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	// clock, 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// model copy of the registers and held state
	logic [7:0]  win_low = fct_pkg::TEMP_LOW_RST;
	logic [7:0]  win_high = fct_pkg::TEMP_HIGH_RST;
	logic [7:0]  lim_floor = fct_pkg::FLOOR_RST;
	logic [7:0]  lim_ceiling = fct_pkg::CEILING_RST;
	logic [7:0]  boost_level = fct_pkg::BOOST_RST;
	logic [7:0]  cpu_temp_kept = fct_pkg::HELD_TEMP_RST;
	logic [7:0]  gpu_temp_kept = fct_pkg::HELD_TEMP_RST;
	logic [7:0]  limit_sent = fct_pkg::LAST_LIMIT_RST;
	logic [7:0]  mode_sent = fct_pkg::MODE_QUIET;
	logic [15:0] cpu_rpm_kept = fct_pkg::HELD_RPM_RST;
	logic [15:0] gpu_rpm_kept = fct_pkg::HELD_RPM_RST;

	// fan curve points, unused points read as zero
	int curve_deg [16] = '{70, 78, 84, 88, 90, 95, 100, 0, 0, 0, 0, 0, 0, 0, 0, 0};
	int curve_spd [16] = '{22, 24, 26, 28, 30, 35, 49, 0, 0, 0, 0, 0, 0, 0, 0, 0};

	sensor_reading_t pending_readings [$];
	fan_response_t   expected_responses [$];

	int error_count = 0;
	int send_gap = 0;
	bit send_idle = 1'b1;
	int recv_gap = 0;
	bit recv_idle = 1'b1;
	int responses_seen = 0;
	sensor_reading_t accepted_reading;
	sensor_reading_t next_reading;

	// interpolated fan limit for a temperature, rounded half away from zero
	function automatic int interpolate_limit(input int deg);
		int rows, seg, idx, x1, y1, x2, y2, den, num, mag, q;
		bit found;
		rows = fct_pkg::NUM_POINTS_DEF;
		if (rows < 2) rows = 2;
		if (rows > 16) rows = 16;
		seg = -1;
		found = 1'b0;
		for (idx = 0; idx < rows; idx++) begin
			if (!found) begin
				if (curve_deg[idx] > deg) begin
					seg = idx - 1;
					found = 1'b1;
				end else begin
					seg = idx;
				end
			end
		end
		if (seg < 0) seg = 0;
		else if (seg >= rows - 1) seg = rows - 2;
		x1 = curve_deg[seg];
		y1 = curve_spd[seg];
		x2 = curve_deg[seg + 1];
		y2 = curve_spd[seg + 1];
		den = x2 - x1;
		if (den == 0) return y1;
		num = (y2 - y1) * (deg - x1);
		if (den < 0) begin
			den = -den;
			num = -num;
		end
		mag = (num < 0) ? -num : num;
		q = (2 * mag + den) / (2 * den);
		return (num < 0) ? y1 - q : y1 + q;
	endfunction

	// one control tick of the model
	function automatic fan_response_t advance_controller(input sensor_reading_t rd);
		fan_response_t rsp;
		int hot, lim;
		logic [7:0] want_mode;
		rsp = '0;
		if (rd.cpu_temp >= win_low && rd.cpu_temp <= win_high) cpu_temp_kept = rd.cpu_temp;
		if (rd.gpu_temp >= win_low && rd.gpu_temp <= win_high) gpu_temp_kept = rd.gpu_temp;
		hot = (cpu_temp_kept > gpu_temp_kept) ? cpu_temp_kept : gpu_temp_kept;
		lim = interpolate_limit(hot);
		// floor is checked first: with crossed clamps a limit below the floor takes the floor, one at or above it the ceiling
		if (lim < int'(lim_floor)) lim = lim_floor;
		else if (lim > int'(lim_ceiling)) lim = lim_ceiling;
		if (int'(limit_sent) != lim) begin
			want_mode = (lim <= int'(boost_level)) ? fct_pkg::MODE_QUIET : fct_pkg::MODE_PERF;
			if (mode_sent != want_mode) begin
				mode_sent = want_mode;
				rsp.mode_wr = 1'b1;
			end
			limit_sent = lim[7:0];
			rsp.limit_wr = 1'b1;
		end
		if (rd.cpu_hi != 0 && rd.cpu_lo != 0)
			cpu_rpm_kept = 16'(rd.cpu_hi * 16'd255 + rd.cpu_lo);
		if (rd.gpu_hi != 0 && rd.gpu_lo != 0)
			gpu_rpm_kept = 16'(rd.gpu_hi * 16'd255 + rd.gpu_lo);
		rsp.mode = mode_sent;
		rsp.limit = limit_sent;
		rsp.cpu_temp = cpu_temp_kept;
		rsp.gpu_temp = gpu_temp_kept;
		rsp.cpu_rpm = cpu_rpm_kept;
		rsp.gpu_rpm = gpu_rpm_kept;
		return rsp;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $realtime, name, want, got);
		end
	endfunction

	// sender: presents queued readings, predicts on every accepted request
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				accepted_reading = {cpu_temp_raw, gpu_temp_raw, cpu_tach_high, cpu_tach_low,
					gpu_tach_high, gpu_tach_low};
				expected_responses.push_back(advance_controller(accepted_reading));
			end
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_readings.size() != 0) begin
					next_reading = pending_readings.pop_front();
					cpu_temp_raw <= next_reading.cpu_temp;
					gpu_temp_raw <= next_reading.gpu_temp;
					cpu_tach_high <= next_reading.cpu_hi;
					cpu_tach_low <= next_reading.cpu_lo;
					gpu_tach_high <= next_reading.gpu_hi;
					gpu_tach_low <= next_reading.gpu_lo;
					in_valid <= 1'b1;
					send_gap = send_idle ? $urandom_range(0, 3) : 0;
					if ($urandom_range(0, 39) == 0) send_idle = !send_idle;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each response against the oldest prediction
	always @(posedge clk) begin
		fan_response_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_responses.size() == 0) begin
					error_count++;
					$display("%0t: response with no request outstanding, expected none actual limit %0d",
						$realtime, limit_value);
				end else begin
					want = expected_responses.pop_front();
					check_field("mode_write_valid", want.mode_wr, mode_write_valid);
					check_field("mode_value", want.mode, mode_value);
					check_field("limit_write_valid", want.limit_wr, limit_write_valid);
					check_field("limit_value", want.limit, limit_value);
					check_field("cpu_temp_held", want.cpu_temp, cpu_temp_held);
					check_field("gpu_temp_held", want.gpu_temp, gpu_temp_held);
					check_field("cpu_fan_rpm", want.cpu_rpm, cpu_fan_rpm);
					check_field("gpu_fan_rpm", want.gpu_rpm, gpu_fan_rpm);
				end
				responses_seen++;
				recv_gap = recv_idle ? $urandom_range(0, 3) : 0;
				if ($urandom_range(0, 39) == 0) recv_idle = !recv_idle;
				// long back-pressure so the block fills and stalls its input
				if (responses_seen == 200 || responses_seen == 900) recv_gap = 400;
			end else if (recv_gap != 0) begin
				recv_gap--;
			end
			out_ready <= (recv_gap == 0);
		end
	end

	function automatic void queue_reading(input int ct, input int gt, input int chi,
			input int clo, input int ghi, input int glo);
		pending_readings.push_back({8'(ct), 8'(gt), 8'(chi), 8'(clo), 8'(ghi), 8'(glo)});
	endfunction

	// random tach byte, zero now and then so the held speed path is exercised
	function automatic int tach_byte();
		return ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 255);
	endfunction

	// random temperature, mostly around the curve
	function automatic int temp_byte();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(45, 120);
	endfunction

	function automatic void queue_random(input int count);
		int n;
		for (n = 0; n < count; n++)
			queue_reading(temp_byte(), temp_byte(), tach_byte(), tach_byte(), tach_byte(),
				tach_byte());
	endfunction

	// register write, called at a rising edge; leaves cfg_valid high
	task automatic write_register(input logic [2:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			fct_pkg::REG_TEMP_VALID_LOW:  win_low = val;
			fct_pkg::REG_TEMP_VALID_HIGH: win_high = val;
			fct_pkg::REG_SPEED_FLOOR:     lim_floor = val;
			fct_pkg::REG_SPEED_CEILING:   lim_ceiling = val;
			fct_pkg::REG_BOOST_THRESHOLD: boost_level = val;
			default: ;
		endcase
	endtask

	task automatic load_settings(input int low, input int high, input int flr, input int ceil,
			input int boost);
		write_register(fct_pkg::REG_TEMP_VALID_LOW, 8'(low));
		write_register(fct_pkg::REG_TEMP_VALID_HIGH, 8'(high));
		write_register(fct_pkg::REG_SPEED_FLOOR, 8'(flr));
		write_register(fct_pkg::REG_SPEED_CEILING, 8'(ceil));
		write_register(fct_pkg::REG_BOOST_THRESHOLD, 8'(boost));
		cfg_valid <= 1'b0;
	endtask

	// returns at a rising edge once every request has been answered
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_readings.size() != 0 || in_valid || expected_responses.size() != 0);
		@(posedge clk);
	endtask

	// stimulus sequence
	initial begin
		int k;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: window edges, every curve segment but 84 to 88, rounding and clamps
		queue_reading(0, 255, 0, 0, 0, 0);
		queue_reading(55, 110, 255, 255, 255, 255);
		queue_reading(54, 111, 0, 7, 7, 0);
		queue_reading(70, 70, 1, 1, 1, 1);
		queue_reading(72, 60, 3, 200, 200, 3);
		queue_reading(76, 55, 10, 20, 30, 40);
		queue_reading(78, 78, 10, 20, 30, 40);
		queue_reading(81, 56, 1, 255, 255, 1);
		queue_reading(88, 88, 2, 2, 2, 2);
		queue_reading(89, 57, 2, 2, 2, 2);
		queue_reading(92, 90, 2, 2, 2, 2);
		queue_reading(95, 95, 2, 2, 2, 2);
		queue_reading(96, 95, 2, 2, 2, 2);
		queue_reading(100, 100, 2, 2, 2, 2);
		queue_reading(105, 101, 2, 2, 2, 2);
		queue_reading(60, 65, 2, 2, 2, 2);
		queue_reading(97, 55, 2, 2, 2, 2);
		queue_reading(97, 55, 128, 128, 127, 127);
		queue_reading(68, 68, 85, 170, 170, 85);
		wait_drained();

		// widest window and clamps, quiet mode throughout
		load_settings(0, 255, 0, 255, 255);
		queue_reading(0, 0, 1, 1, 1, 1);
		queue_reading(68, 0, 1, 1, 1, 1);
		queue_reading(255, 255, 1, 1, 1, 1);
		queue_random(50);
		wait_drained();

		// empty window and crossed clamps, boost at zero
		load_settings(255, 0, 255, 0, 0);
		queue_random(30);
		wait_drained();

		// main random run, with the long receiver stalls
		write_register(REG_UNUSED, 8'hFF);
		load_settings(60, 105, 24, 45, 30);
		queue_random(1020);
		wait_drained();

		// a few random settings
		for (k = 0; k < 3; k++) begin
			load_settings($urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
			queue_random(60);
			wait_drained();
		end

		// allow for any stray response
		repeat (80) @(posedge clk);
		if (error_count == 0 && expected_responses.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog
	initial begin
		#1000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/fct_pkg.sv
rtl/fct_divider.sv
rtl/fan_curve_thermal_controller.sv
bench/testbench.sv
